// File: rtl/partition_fit_allocator_core_macros.svh
// assertion helpers for the partition fit allocator
`ifndef PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH
`define PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTH

`define PFA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PFA_ASSERT(lbl, clk, rst_n, prop, msg)

`define PFA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/pfa_pkg.sv
package pfa_pkg;

  localparam int unsigned NUM_PARTS = 8;
  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned STRAT_W   = 2;
  localparam int unsigned IDX_W     = $clog2(REG_COUNT);
  localparam int unsigned SCAN_N    = (NUM_PARTS > REG_COUNT) ? REG_COUNT : NUM_PARTS;
  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SCAN_N - 1);

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOFIT = 1'b1;

  typedef enum logic [STRAT_W-1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_BEST  = 2'd1,
    STRAT_WORST = 2'd2,
    STRAT_NONE  = 2'd3
  } strategy_e;

  typedef logic [SIZE_W-1:0] space_t;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] idx;
    space_t           left;
  } pfa_res_t;

endpackage

// File: rtl/pfa_scan.sv
module pfa_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      stall_i,
  input  pfa_pkg::space_t           req_i,
  input  pfa_pkg::strategy_e        strat_i,
  input  pfa_pkg::space_t           room_i,
  output logic [pfa_pkg::IDX_W-1:0] rd_idx_o,
  output logic                      idle_o,
  output logic                      done_o,
  output pfa_pkg::pfa_res_t         res_o
);
  import pfa_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] pick_q, pick_d;
  space_t           best_q, best_d;
  space_t           req_q, req_d;
  strategy_e        strat_q, strat_d;

  // shared subtract and compare
  space_t        sub_a;
  logic [SIZE_W:0] diff;
  logic          fits;
  space_t        left;
  space_t        cmp_a, cmp_b;
  logic          less;
  logic          ok;
  space_t        res_left;

  assign sub_a = (state_q == ST_FINISH) ? best_q : room_i;
  assign diff  = {1'b0, sub_a} - {1'b0, req_q};
  assign fits  = ~diff[SIZE_W];
  assign left  = diff[SIZE_W-1:0];
  assign cmp_a = (strat_q == STRAT_WORST) ? best_q : left;
  assign cmp_b = (strat_q == STRAT_WORST) ? room_i : best_q;
  assign less  = cmp_a < cmp_b;

  always_comb begin
    case (strat_q)
      STRAT_FIRST, STRAT_BEST: begin
        ok       = found_q;
        res_left = best_q;
      end
      STRAT_WORST: begin
        ok       = fits;
        res_left = left;
      end
      default: begin
        ok       = 1'b0;
        res_left = '0;
      end
    endcase
  end

  assign res_o.status = ok ? STATUS_OK : STATUS_NOFIT;
  assign res_o.idx    = ok ? pick_q : '0;
  assign res_o.left   = ok ? res_left : '0;

  assign rd_idx_o = idx_q;
  assign idle_o   = (state_q == ST_IDLE);
  assign done_o   = (state_q == ST_FINISH) && !stall_i;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    found_d = found_q;
    pick_d  = pick_q;
    best_d  = best_q;
    req_d   = req_q;
    strat_d = strat_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SCAN;
          idx_d   = '0;
          found_d = 1'b0;
          pick_d  = '0;
          best_d  = '0;
          req_d   = req_i;
          strat_d = strat_i;
        end
      end
      ST_SCAN: begin
        case (strat_q)
          STRAT_FIRST: begin
            if (fits && !found_q) begin
              found_d = 1'b1;
              pick_d  = idx_q;
              best_d  = left;
            end
          end
          STRAT_BEST: begin
            if (fits && (!found_q || less)) begin
              found_d = 1'b1;
              pick_d  = idx_q;
              best_d  = left;
            end
          end
          STRAT_WORST: begin
            if ((idx_q == '0) || less) begin
              pick_d = idx_q;
              best_d = room_i;
            end
          end
          default: ;
        endcase
        if (idx_q == SCAN_LAST) begin
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q  <= pick_d;
    best_q  <= best_d;
    req_q   <= req_d;
    strat_q <= strat_d;
  end

endmodule

// File: rtl/partition_fit_allocator_core.sv
// An accepted item is scanned, and its result is registered from the final state into the output register.
// The scan reads one partition per cycle through a shared subtract/compare unit, then
// passes a final state and returns to idle, the only state in which a new item is accepted.
// A result held by output back-pressure stalls the final state.
// Reset (async, active low) clears all free space to zero and idles the block.
module partition_fit_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pfa_pkg::SIZE_W-1:0]  request_size_i,
  input  logic [pfa_pkg::STRAT_W-1:0] strategy_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        status_o,
  output logic [pfa_pkg::IDX_W-1:0]   part_index_o,
  output logic [pfa_pkg::SIZE_W-1:0]  space_left_o,
  input  logic                        cfg_we_i,
  input  logic [pfa_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [pfa_pkg::SIZE_W-1:0]  cfg_data_i
);
  import pfa_pkg::*;

  `include "partition_fit_allocator_core_macros.svh"

  space_t           free_q [REG_COUNT];
  logic [IDX_W-1:0] rd_idx;
  logic             scan_idle;
  logic             scan_done;
  logic             start;
  logic             stall;
  pfa_res_t         res;

  logic             out_valid_q, out_valid_d;
  pfa_res_t         out_q;

  assign start      = in_valid_i && in_ready_o;
  assign stall      = out_valid_q && !out_ready_i;
  assign in_ready_o = scan_idle;

  pfa_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .stall_i  (stall),
    .req_i    (request_size_i),
    .strat_i  (strategy_e'(strategy_i)),
    .room_i   (free_q[rd_idx]),
    .rd_idx_o (rd_idx),
    .idle_o   (scan_idle),
    .done_o   (scan_done),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        free_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      free_q[cfg_index_i] <= cfg_data_i;
    end else if (scan_done && (res.status == STATUS_OK)) begin
      free_q[res.idx] <= res.left;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (scan_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_done) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign part_index_o = out_q.idx;
  assign space_left_o = out_q.left;

  `PFA_ASSERT(a_busy_after_accept, clk_i, rst_ni, start |=> !in_ready_o, "accepted item did not start a scan")
  `PFA_ASSERT(a_alloc_updates_space, clk_i, rst_ni, (scan_done && (res.status == STATUS_OK)) |=> (free_q[part_index_o] == space_left_o), "free space not updated with result")
  `PFA_ASSERT_ALWAYS(a_nofit_zero, clk_i, (out_valid_o && (status_o == STATUS_NOFIT)) |-> ((part_index_o == '0) && (space_left_o == '0)), "no-fit result carries nonzero fields")

endmodule
